### src/rbrt_pkg.sv
// Shared types and constants for the resource block reservation table.
package rbrt_pkg;

  // Fixed field widths of the request and result channels.
  localparam int OPCODE_W = 2;
  localparam int SLOT_W   = 31;
  localparam int BLK_W    = 6;
  localparam int MAP_W    = 64;

  // Default sizing of the table.
  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int BLOCK_COUNT_DEF   = 64;

  // Operation codes carried by a request.
  typedef enum logic [OPCODE_W-1:0] {
    OP_ADD    = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_DELETE = 2'd2,
    OP_PURGE  = 2'd3
  } opcode_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_READ,
    S_UPDATE,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic match;
    logic read;
    logic update;
    logic load_out;
  } cmd_t;

endpackage

### src/rbrt_if.sv
// Request and result channel interfaces for the reservation table.
interface rbrt_in_if;
  import rbrt_pkg::*;

  logic              valid;
  logic              ready;
  logic [OPCODE_W-1:0] opcode;
  logic [SLOT_W-1:0] slot_number;
  logic [BLK_W-1:0]  block_index;

  modport source (output valid, output opcode, output slot_number, output block_index,
                  input ready);
  modport sink (input valid, input opcode, input slot_number, input block_index,
                output ready);
endinterface

interface rbrt_out_if;
  import rbrt_pkg::*;

  logic             valid;
  logic             ready;
  logic             status;
  logic             slot_exists;
  logic             block_reserved;
  logic [MAP_W-1:0] block_map;

  modport source (output valid, output status, output slot_exists, output block_reserved,
                  output block_map, input ready);
  modport sink (input valid, input status, input slot_exists, input block_reserved,
                input block_map, output ready);
endinterface

### src/rbrt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rbrt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds between reads.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/rbrt_ctrl.sv
// Controller state machine that sequences one request through the datapath.
module rbrt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output rbrt_pkg::cmd_t cmd
);
  import rbrt_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // The result register can take a new result when empty or being drained.
  assign out_free = !out_valid_r || out_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_MATCH;
      S_MATCH:  state_nxt = S_READ;
      S_READ:   state_nxt = S_UPDATE;
      S_UPDATE: state_nxt = S_DONE;
      S_DONE:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Commands and handshake outputs.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_MATCH:  cmd.match    = 1'b1;
      S_READ:   cmd.read     = 1'b1;
      S_UPDATE: cmd.update   = 1'b1;
      S_DONE:   cmd.load_out = out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

  // Result valid flag: set on load, cleared when the result is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### src/rbrt_dp.sv
// Datapath: tag cells, valid bits, bitmap memory and result registers.
module rbrt_dp #(
  parameter int TABLE_ENTRIES = rbrt_pkg::TABLE_ENTRIES_DEF,
  parameter int BLOCK_COUNT   = rbrt_pkg::BLOCK_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rbrt_pkg::cmd_t                cmd,
  input  logic [rbrt_pkg::OPCODE_W-1:0] in_opcode,
  input  logic [rbrt_pkg::SLOT_W-1:0]   in_slot_number,
  input  logic [rbrt_pkg::BLK_W-1:0]    in_block_index,
  output logic                          out_status,
  output logic                          out_slot_exists,
  output logic                          out_block_reserved,
  output logic [rbrt_pkg::MAP_W-1:0]    out_block_map
);
  import rbrt_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [BLK_W:0] BLK_LIMIT = (BLK_W+1)'(BLOCK_COUNT);
  localparam logic [BLOCK_COUNT-1:0] MAP_ONE = {{(BLOCK_COUNT-1){1'b0}}, 1'b1};

  // Captured request.
  opcode_t            op_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [BLK_W-1:0]   blk_r;

  // Table state held in cells.
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [SLOT_W-1:0]        tag_r [TABLE_ENTRIES];

  // Match stage results.
  logic [TABLE_ENTRIES-1:0] hit_vec, older_vec, free_oh;
  logic [IDX_W-1:0]         hit_idx, free_idx;
  logic [TABLE_ENTRIES-1:0] hit_r, older_r;
  logic [IDX_W-1:0]         hit_idx_r, free_idx_r;
  logic                     any_hit_r, full_r;

  // Update stage signals.
  logic [BLOCK_COUNT-1:0] rd_map, cur_map, blk_bit;
  logic                   blk_ok;
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [BLOCK_COUNT-1:0] ram_wdata;
  logic                   claim;

  // Result held until the output register is free.
  logic                   res_status_r, res_exists_r, res_reserved_r;
  logic [MAP_W-1:0]       res_map_r;

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= opcode_t'(in_opcode);
      slot_r <= in_slot_number;
      blk_r  <= in_block_index;
    end
  end

  // Parallel tag compare, age compare and lowest free entry.
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit_vec[i]   = valid_r[i] && (tag_r[i] == slot_r);
      older_vec[i] = valid_r[i] && (tag_r[i] < slot_r);
    end
    free_oh = ~valid_r & (valid_r + TABLE_ENTRIES'(1));
    // Tags of valid entries are unique, so the hit vector is one-hot or empty.
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (hit_vec[i]) hit_idx = hit_idx | IDX_W'(i);
      if (free_oh[i]) free_idx = free_idx | IDX_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.match) begin
      hit_r      <= hit_vec;
      older_r    <= older_vec;
      hit_idx_r  <= hit_idx;
      free_idx_r <= free_idx;
      any_hit_r  <= |hit_vec;
      full_r     <= &valid_r;
    end
  end

  // Bitmap memory, read at the matching entry.
  rbrt_ram #(
    .WIDTH (BLOCK_COUNT),
    .DEPTH (TABLE_ENTRIES)
  ) u_map_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.read),
    .raddr (hit_idx_r),
    .rdata (rd_map)
  );

  // Update stage: current bitmap and the block's bit.
  assign cur_map = any_hit_r ? rd_map : '0;
  assign blk_ok  = {1'b0, blk_r} < BLK_LIMIT;
  assign blk_bit = blk_ok ? (MAP_ONE << blk_r) : '0;
  assign claim   = cmd.update && (op_r == OP_ADD) && blk_ok && !any_hit_r && !full_r;

  // Bitmap write: merge into an existing entry or start a new one.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = hit_idx_r;
    ram_wdata = cur_map | blk_bit;
    if (cmd.update && (op_r == OP_ADD) && blk_ok) begin
      if (any_hit_r) begin
        ram_we = 1'b1;
      end else if (!full_r) begin
        ram_we    = 1'b1;
        ram_waddr = free_idx_r;
        ram_wdata = blk_bit;
      end
    end
  end

  // Valid bits.
  always_comb begin
    valid_nxt = valid_r;
    if (cmd.update) begin
      unique case (op_r)
        OP_ADD:    if (claim) valid_nxt[free_idx_r] = 1'b1;
        OP_LOOKUP: valid_nxt = valid_r;
        OP_DELETE: valid_nxt = valid_r & ~hit_r;
        OP_PURGE:  valid_nxt = valid_r & ~older_r;
        default:   valid_nxt = valid_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Tag written when a new entry is claimed.
  always_ff @(posedge clk) begin
    if (claim) begin
      tag_r[free_idx_r] <= slot_r;
    end
  end

  // Result as seen before the operation.
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      res_status_r   <= (op_r == OP_ADD) && blk_ok && !any_hit_r && full_r;
      res_exists_r   <= any_hit_r;
      res_reserved_r <= |(cur_map & blk_bit);
      res_map_r      <= MAP_W'(cur_map);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status         <= res_status_r;
      out_slot_exists    <= res_exists_r;
      out_block_reserved <= res_reserved_r;
      out_block_map      <= res_map_r;
    end
  end

endmodule

### src/resource_block_reservation_table_core.sv
// A request passes through the compare, read, update and done states before its result is valid.
// A new request is taken only after the last one is through; the registered tag compare and the
// registered read of the bitmap memory each have a state of their own.
// A finished result waits in the output register while the next request is taken.
// Reset (synchronous, active low) clears all valid bits and the control state;
// tags and bitmaps are left as they are and are only read behind a valid bit.
module resource_block_reservation_table_core #(
  parameter int TABLE_ENTRIES = rbrt_pkg::TABLE_ENTRIES_DEF,
  parameter int BLOCK_COUNT   = rbrt_pkg::BLOCK_COUNT_DEF
) (
  input logic          clk,
  input logic          rst_n,
  rbrt_in_if.sink      in_if,
  rbrt_out_if.source   out_if
);
  import rbrt_pkg::*;

  cmd_t cmd;

  // Sequencing.
  rbrt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cmd       (cmd)
  );

  // Table storage and result computation.
  rbrt_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .BLOCK_COUNT   (BLOCK_COUNT)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_opcode          (in_if.opcode),
    .in_slot_number     (in_if.slot_number),
    .in_block_index     (in_if.block_index),
    .out_status         (out_if.status),
    .out_slot_exists    (out_if.slot_exists),
    .out_block_reserved (out_if.block_reserved),
    .out_block_map      (out_if.block_map)
  );

  // An accepted request moves to the compare stage in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> cmd.match)
    else $error("accepted request did not reach the compare stage");

  // Compare, read and update follow each other without gaps.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.match |=> cmd.read ##1 cmd.update)
    else $error("compare, read and update out of sequence");

  // At most one command is active in any cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.capture, cmd.match, cmd.read, cmd.update, cmd.load_out}))
    else $error("more than one datapath command active");

  // A dropped add always refers to a slot that had no entry.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> !(out_if.status && out_if.slot_exists))
    else $error("table full reported for an existing slot");

endmodule

### bench/resource_block_reservation_table_core_tb.sv
// Self-checking testbench for the resource block reservation table core.
module resource_block_reservation_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rbrt_pkg::*;

  localparam int TBL_N = TABLE_ENTRIES_DEF;
  localparam int BLK_N = BLOCK_COUNT_DEF;
  localparam logic [SLOT_W-1:0] SLOT_MAX = {SLOT_W{1'b1}};

  typedef struct packed {
    opcode_t           op;
    logic [SLOT_W-1:0] slot;
    logic [BLK_W-1:0]  blk;
  } req_t;

  typedef struct packed {
    logic             status;
    logic             slot_exists;
    logic             block_reserved;
    logic [MAP_W-1:0] block_map;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rbrt_in_if  in_ch ();
  rbrt_out_if out_ch ();

  resource_block_reservation_table_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  always #5ns clk = ~clk;

  // Shadow copy of the table, kept in step with accepted requests.
  logic             resv_valid [TBL_N];
  logic [SLOT_W-1:0] resv_tag  [TBL_N];
  logic [MAP_W-1:0] resv_map   [TBL_N];

  req_t   req_backlog[$];
  reply_t predicted_replies[$];
  req_t   in_flight;
  int     sender_idle_pct = 0;
  int     recv_stall_pct = 0;
  int     mismatch_count = 0;

  // Applies one request to the shadow table and returns the reply it must produce.
  function automatic reply_t reservation_apply(req_t r);
    reply_t           rep;
    int               hit;
    int               free_idx;
    logic             blk_ok;
    logic [MAP_W-1:0] bit_sel;
    logic [MAP_W-1:0] cur_map;
    hit = -1;
    free_idx = -1;
    blk_ok = (int'(r.blk) < BLK_N);
    bit_sel = blk_ok ? (64'd1 << r.blk) : '0;
    for (int i = TBL_N - 1; i >= 0; i--) begin
      if (resv_valid[i] && resv_tag[i] == r.slot) hit = i;
      if (!resv_valid[i]) free_idx = i;
    end
    cur_map = (hit >= 0) ? resv_map[hit] : '0;
    rep.status = 1'b0;
    rep.slot_exists = (hit >= 0);
    rep.block_reserved = |(cur_map & bit_sel);
    rep.block_map = cur_map;
    case (r.op)
      OP_ADD: begin
        if (blk_ok) begin
          if (hit >= 0) begin
            resv_map[hit] = resv_map[hit] | bit_sel;
          end else if (free_idx < 0) begin
            rep.status = 1'b1;
          end else begin
            resv_valid[free_idx] = 1'b1;
            resv_tag[free_idx] = r.slot;
            resv_map[free_idx] = bit_sel;
          end
        end
      end
      OP_LOOKUP: begin
      end
      OP_DELETE: begin
        if (hit >= 0) resv_valid[hit] = 1'b0;
      end
      default: begin
        // Purge drops every slot numbered below the request's slot.
        for (int i = 0; i < TBL_N; i++) begin
          if (resv_valid[i] && resv_tag[i] < r.slot) resv_valid[i] = 1'b0;
        end
      end
    endcase
    return rep;
  endfunction

  task automatic report_mismatch(string what, logic [MAP_W-1:0] got, logic [MAP_W-1:0] want);
    mismatch_count++;
    $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
  endtask

  task automatic push_req(opcode_t op, logic [SLOT_W-1:0] slot, logic [BLK_W-1:0] blk);
    req_t r;
    r.op = op;
    r.slot = slot;
    r.blk = blk;
    req_backlog = {req_backlog, r};
  endtask

  // Random traffic around a sliding window of slot numbers, as a scheduler sees it.
  task automatic queue_traffic(int count);
    logic [SLOT_W-1:0] base;
    logic [SLOT_W-1:0] slot;
    int                pick;
    base = SLOT_W'($urandom);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) begin
        slot = SLOT_W'($urandom);
      end else begin
        slot = base + SLOT_W'($urandom_range(0, 23));
      end
      if (pick < 45) begin
        push_req(OP_ADD, slot, BLK_W'($urandom_range(0, 63)));
      end else if (pick < 70) begin
        push_req(OP_LOOKUP, slot, BLK_W'($urandom_range(0, 63)));
      end else if (pick < 85) begin
        push_req(OP_DELETE, slot, BLK_W'($urandom_range(0, 63)));
      end else begin
        push_req(OP_PURGE, base + SLOT_W'($urandom_range(0, 12)),
                 BLK_W'($urandom_range(0, 63)));
        base = base + SLOT_W'($urandom_range(0, 8));
      end
    end
  endtask

  task automatic drain_backlog();
    while (req_backlog.size() != 0 || in_ch.valid) @(posedge clk);
  endtask

  // Request driver: presents queued requests and predicts each one as it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predicted_replies = {predicted_replies, reservation_apply(in_flight)};
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (req_backlog.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          in_flight = req_backlog.pop_front();
          in_ch.opcode <= in_flight.op;
          in_ch.slot_number <= in_flight.slot;
          in_ch.block_index <= in_flight.blk;
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each accepted result against the oldest prediction.
  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (predicted_replies.size() == 0) begin
        report_mismatch("unexpected result map", out_ch.block_map, '0);
      end else begin
        want = predicted_replies.pop_front();
        if (out_ch.status !== want.status)
          report_mismatch("status", MAP_W'(out_ch.status), MAP_W'(want.status));
        if (out_ch.slot_exists !== want.slot_exists)
          report_mismatch("slot_exists", MAP_W'(out_ch.slot_exists),
                          MAP_W'(want.slot_exists));
        if (out_ch.block_reserved !== want.block_reserved)
          report_mismatch("block_reserved", MAP_W'(out_ch.block_reserved),
                          MAP_W'(want.block_reserved));
        if (out_ch.block_map !== want.block_map)
          report_mismatch("block_map", out_ch.block_map, want.block_map);
      end
    end
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Main sequence: reset, directed requests, then random traffic in phases of sender idling and receiver stalls.
  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_LOOKUP;
    in_ch.slot_number = '0;
    in_ch.block_index = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < TBL_N; i++) begin
      resv_valid[i] = 1'b0;
      resv_tag[i] = '0;
      resv_map[i] = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Lowest and highest slot and block, a duplicate add, and both edge slots.
    push_req(OP_ADD, '0, '0);
    push_req(OP_ADD, '0, BLK_W'(63));
    push_req(OP_ADD, '0, BLK_W'(63));
    push_req(OP_LOOKUP, '0, BLK_W'(63));
    push_req(OP_ADD, SLOT_MAX, BLK_W'(5));
    push_req(OP_LOOKUP, SLOT_MAX, '0);
    // Delete of an absent slot and a purge with nothing older change nothing.
    push_req(OP_DELETE, SLOT_W'(12345), '0);
    push_req(OP_PURGE, '0, '0);
    // Fill the table, then try a new slot and an existing one while it is full.
    for (int i = 0; i < TBL_N - 2; i++) push_req(OP_ADD, SLOT_W'(100 + i), BLK_W'(i));
    push_req(OP_ADD, SLOT_W'(200), BLK_W'(1));
    push_req(OP_ADD, SLOT_W'(100), BLK_W'(7));
    push_req(OP_DELETE, SLOT_MAX, '0);
    push_req(OP_PURGE, SLOT_MAX, '0);
    push_req(OP_LOOKUP, '0, '0);
    queue_traffic(275);
    drain_backlog();

    sender_idle_pct = 81;
    queue_traffic(275);
    drain_backlog();

    sender_idle_pct = 0;
    recv_stall_pct = 81;
    queue_traffic(275);
    drain_backlog();

    sender_idle_pct = 27;
    recv_stall_pct = 27;
    queue_traffic(275);
    drain_backlog();

    while (predicted_replies.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5ms;
    $display("timeout with %0d results outstanding", predicted_replies.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
